// ----- rtl/nsf_pkg.sv -----
package nsf_pkg;

    // Binary32 constants used by the Newton loop and the float unit.
    localparam logic [31:0] SQRT2_BITS   = 32'h3FB5_04F3;
    localparam logic [31:0] HALF_BITS    = 32'h3F00_0000;
    localparam logic [31:0] QNAN_DEFAULT = 32'hFFC0_0000;
    localparam logic [31:0] QNAN_DIVZERO = 32'h7FC0_0000;
    localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;
    localparam logic [7:0]  EXP_BIAS     = 8'd127;

    // Configuration register map and reset values.
    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 8'd1;
    localparam logic [31:0] TOL_RESET   = 32'h3727_C5AC;
    localparam logic [6:0]  MAXIT_RESET = 7'd32;
    localparam logic [6:0]  ITER_CAP    = 7'd64;

    // Float unit operation codes.
    typedef logic [1:0] fop_t;
    localparam fop_t FOP_ADD = 2'd0;
    localparam fop_t FOP_SUB = 2'd1;
    localparam fop_t FOP_MUL = 2'd2;
    localparam fop_t FOP_DIV = 2'd3;

    // Steps of one item: the guess scaling and the four operations of a Newton step.
    typedef logic [2:0] step_t;
    localparam step_t STEP_GUESS = 3'd0;
    localparam step_t STEP_DIV   = 3'd1;
    localparam step_t STEP_ADD   = 3'd2;
    localparam step_t STEP_HALF  = 3'd3;
    localparam step_t STEP_DIFF  = 3'd4;

    typedef struct packed {
        logic  load;
        logic  start;
        logic  capture;
        logic  check;
        logic  out_load;
        step_t step;
    } nsf_cmd_t;

    typedef struct packed {
        logic guess_odd;
        logic conv_hit;
        logic last_iter;
        logic fpu_done;
    } nsf_status_t;

    function automatic logic fp_is_nan(input logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    endfunction

    // Ordered less-than; false when either side is NaN.
    function automatic logic fp_lt(input logic [31:0] x, input logic [31:0] y);
        logic lt_r;
        if (fp_is_nan(x) || fp_is_nan(y)) begin
            lt_r = 1'b0;
        end else if ((x[30:0] == 31'd0) && (y[30:0] == 31'd0)) begin
            lt_r = 1'b0;
        end else if (x[31] != y[31]) begin
            lt_r = x[31];
        end else if (!x[31]) begin
            lt_r = x[30:0] < y[30:0];
        end else begin
            lt_r = x[30:0] > y[30:0];
        end
        return lt_r;
    endfunction

    // Ordered equality; the two zeros compare equal.
    function automatic logic fp_eq(input logic [31:0] x, input logic [31:0] y);
        logic eq_r;
        if (fp_is_nan(x) || fp_is_nan(y)) begin
            eq_r = 1'b0;
        end else begin
            eq_r = (x == y) || ((x[30:0] == 31'd0) && (y[30:0] == 31'd0));
        end
        return eq_r;
    endfunction

endpackage

// ----- rtl/nsf_fpu.sv -----
module nsf_fpu (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  nsf_pkg::fop_t op,
    input  logic [31:0]   a,
    input  logic [31:0]   b,
    output logic          done,
    output logic [31:0]   result
);
    import nsf_pkg::*;

    localparam logic [3:0] F_IDLE  = 4'd0;
    localparam logic [3:0] F_PRE   = 4'd1;
    localparam logic [3:0] F_ALIGN = 4'd2;
    localparam logic [3:0] F_ADDS  = 4'd3;
    localparam logic [3:0] F_DIVS  = 4'd4;
    localparam logic [3:0] F_NORM  = 4'd5;
    localparam logic [3:0] F_SUBN  = 4'd6;
    localparam logic [3:0] F_ROUND = 4'd7;
    localparam logic [3:0] F_DONE  = 4'd8;

    logic [3:0]         state_reg, state_next;
    fop_t               op_reg, op_next;
    logic               sa_reg, sa_next, sb_reg, sb_next;
    logic signed [11:0] ea_reg, ea_next, eb_reg, eb_next;
    logic [23:0]        ma_reg, ma_next, mb_reg, mb_next;
    logic               sgn_reg, sgn_next;
    logic signed [11:0] ex_reg, ex_next;
    logic [49:0]        r_reg, r_next;
    logic [25:0]        rem_reg, rem_next;
    logic [26:0]        q_reg, q_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [11:0]        dist_reg, dist_next;
    logic               sub_reg, sub_next;
    logic [31:0]        res_reg, res_next;

    logic [32:0]        sp;
    logic [47:0]        prod;
    logic               a_big;
    logic [49:0]        big_m, sml_m, shifted, mask, sum;
    logic               st;
    logic               ge;
    logic [25:0]        rem_sub;
    logic [25:0]        rem_sh;
    logic [26:0]        q_sh;
    logic [11:0]        shamt;
    logic [23:0]        rm;
    logic [24:0]        rm_up;
    logic [23:0]        mf;
    logic signed [11:0] ef;

    // Operands that need no arithmetic: NaN, infinity and zero cases.
    function automatic logic [32:0] special_case(input fop_t f, input logic [31:0] x,
                                                 input logic [31:0] y);
        logic xn, yn, xi, yi, xz, yz, ys, s;
        logic [32:0] r;
        xn = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
        yn = (y[30:23] == 8'hFF) && (y[22:0] != 23'd0);
        xi = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
        yi = (y[30:23] == 8'hFF) && (y[22:0] == 23'd0);
        xz = (x[30:0] == 31'd0);
        yz = (y[30:0] == 31'd0);
        ys = y[31] ^ (f == FOP_SUB);
        s  = x[31] ^ y[31];
        r  = 33'd0;
        case (f)
            FOP_DIV: begin
                if (yz) begin
                    r = {1'b1, (xz || xn) ? QNAN_DIVZERO : {s, 8'hFF, 23'd0}};
                end else if (xn) begin
                    r = {1'b1, x | QUIET_BIT};
                end else if (yn) begin
                    r = {1'b1, y | QUIET_BIT};
                end else if (xi && yi) begin
                    r = {1'b1, QNAN_DEFAULT};
                end else if (xi) begin
                    r = {1'b1, s, 8'hFF, 23'd0};
                end else if (yi || xz) begin
                    r = {1'b1, s, 31'd0};
                end
            end
            FOP_MUL: begin
                if (xn) begin
                    r = {1'b1, x | QUIET_BIT};
                end else if (yn) begin
                    r = {1'b1, y | QUIET_BIT};
                end else if ((xi && yz) || (xz && yi)) begin
                    r = {1'b1, QNAN_DEFAULT};
                end else if (xi || yi) begin
                    r = {1'b1, s, 8'hFF, 23'd0};
                end else if (xz || yz) begin
                    r = {1'b1, s, 31'd0};
                end
            end
            default: begin
                if (xn) begin
                    r = {1'b1, x | QUIET_BIT};
                end else if (yn) begin
                    r = {1'b1, y | QUIET_BIT};
                end else if (xi && yi) begin
                    r = {1'b1, (x[31] != ys) ? QNAN_DEFAULT : x};
                end else if (xi) begin
                    r = {1'b1, x};
                end else if (yi) begin
                    r = {1'b1, ys, y[30:0]};
                end else if (xz && yz) begin
                    r = {1'b1, x[31] & ys, 31'd0};
                end else if (xz) begin
                    r = {1'b1, ys, y[30:0]};
                end else if (yz) begin
                    r = {1'b1, x};
                end
            end
        endcase
        return r;
    endfunction

    // Sequencer: unpack, pre-normalize, operate, normalize, round.
    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        sa_next    = sa_reg;
        sb_next    = sb_reg;
        ea_next    = ea_reg;
        eb_next    = eb_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        sgn_next   = sgn_reg;
        ex_next    = ex_reg;
        r_next     = r_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        dist_next  = dist_reg;
        sub_next   = sub_reg;
        res_next   = res_reg;

        sp      = special_case(op, a, b);
        prod    = 48'(ma_reg) * 48'(mb_reg);
        a_big   = (ea_reg > eb_reg) || ((ea_reg == eb_reg) && (ma_reg >= mb_reg));
        big_m   = {1'b0, ma_reg, 25'd0};
        sml_m   = {1'b0, mb_reg, 25'd0};
        mask    = (50'd1 << dist_reg[5:0]) - 50'd1;
        shifted = 50'd0;
        st      = 1'b0;
        if (dist_reg >= 12'd50) begin
            st = 1'b1;
        end else begin
            shifted = sml_m >> dist_reg[5:0];
            st      = |(sml_m & mask);
        end
        sum     = sub_reg ? (big_m - (shifted | {49'd0, st}))
                          : (big_m + (shifted | {49'd0, st}));
        ge      = rem_reg >= {2'b00, mb_reg};
        rem_sub = ge ? (rem_reg - {2'b00, mb_reg}) : rem_reg;
        rem_sh  = {rem_sub[24:0], 1'b0};
        q_sh    = {q_reg[25:0], ge};
        shamt   = 12'(12'sd1 - ex_reg);
        rm      = r_reg[49:26];
        rm_up   = {1'b0, rm} + {24'd0, r_reg[25] & ((|r_reg[24:0]) | rm[0])};
        mf      = rm_up[24] ? rm_up[24:1] : rm_up[23:0];
        ef      = rm_up[24] ? (ex_reg + 12'sd1) : ex_reg;

        unique case (state_reg)
            F_IDLE: begin
                if (start) begin
                    op_next = op;
                    if (sp[32]) begin
                        res_next   = sp[31:0];
                        state_next = F_DONE;
                    end else begin
                        sa_next    = a[31];
                        sb_next    = b[31] ^ (op == FOP_SUB);
                        ea_next    = (a[30:23] == 8'd0) ? 12'sd1 : $signed({4'd0, a[30:23]});
                        eb_next    = (b[30:23] == 8'd0) ? 12'sd1 : $signed({4'd0, b[30:23]});
                        ma_next    = {a[30:23] != 8'd0, a[22:0]};
                        mb_next    = {b[30:23] != 8'd0, b[22:0]};
                        state_next = F_PRE;
                    end
                end
            end
            F_PRE: begin
                if (ma_reg[23] && mb_reg[23]) begin
                    case (op_reg)
                        FOP_MUL: begin
                            r_next     = {prod, 2'b00};
                            ex_next    = ea_reg + eb_reg - 12'sd126;
                            sgn_next   = sa_reg ^ sb_reg;
                            state_next = F_NORM;
                        end
                        FOP_DIV: begin
                            rem_next   = {2'b00, ma_reg};
                            q_next     = 27'd0;
                            cnt_next   = 5'd26;
                            ex_next    = ea_reg - eb_reg + 12'sd127;
                            sgn_next   = sa_reg ^ sb_reg;
                            state_next = F_DIVS;
                        end
                        default: begin
                            state_next = F_ALIGN;
                        end
                    endcase
                end else begin
                    // Subnormal operands: one bit of left shift per cycle.
                    if (!ma_reg[23]) begin
                        ma_next = {ma_reg[22:0], 1'b0};
                        ea_next = ea_reg - 12'sd1;
                    end
                    if (!mb_reg[23]) begin
                        mb_next = {mb_reg[22:0], 1'b0};
                        eb_next = eb_reg - 12'sd1;
                    end
                end
            end
            F_ALIGN: begin
                // Put the larger magnitude on the a side.
                sub_next = sa_reg != sb_reg;
                if (a_big) begin
                    sgn_next  = sa_reg;
                    ex_next   = ea_reg + 12'sd1;
                    dist_next = 12'(ea_reg - eb_reg);
                end else begin
                    sa_next   = sb_reg;
                    sb_next   = sa_reg;
                    ea_next   = eb_reg;
                    eb_next   = ea_reg;
                    ma_next   = mb_reg;
                    mb_next   = ma_reg;
                    sgn_next  = sb_reg;
                    ex_next   = eb_reg + 12'sd1;
                    dist_next = 12'(eb_reg - ea_reg);
                end
                state_next = F_ADDS;
            end
            F_ADDS: begin
                if (sum == 50'd0) begin
                    res_next   = 32'd0;
                    state_next = F_DONE;
                end else begin
                    r_next     = sum;
                    state_next = F_NORM;
                end
            end
            F_DIVS: begin
                // Restoring division, one quotient bit per cycle.
                rem_next = rem_sh;
                q_next   = q_sh;
                if (cnt_reg == 5'd0) begin
                    r_next     = {q_sh, 22'd0, rem_sh != 26'd0};
                    state_next = F_NORM;
                end else begin
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            F_NORM: begin
                if (r_reg[49]) begin
                    state_next = F_SUBN;
                end else begin
                    r_next  = {r_reg[48:0], 1'b0};
                    ex_next = ex_reg - 12'sd1;
                end
            end
            F_SUBN: begin
                // Results below the normal range shift into the subnormal field.
                if (ex_reg < 12'sd1) begin
                    if (shamt >= 12'd50) begin
                        r_next = 50'd1;
                    end else begin
                        r_next = (r_reg >> shamt[5:0])
                               | {49'd0, |(r_reg & ((50'd1 << shamt[5:0]) - 50'd1))};
                    end
                    ex_next = 12'sd1;
                end
                state_next = F_ROUND;
            end
            F_ROUND: begin
                // Round to nearest even and pack.
                if (ef >= 12'sd255) begin
                    res_next = {sgn_reg, 8'hFF, 23'd0};
                end else begin
                    res_next = {sgn_reg, mf[23] ? ef[7:0] : 8'd0, mf[22:0]};
                end
                state_next = F_DONE;
            end
            F_DONE: begin
                state_next = F_IDLE;
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
        op_reg   <= op_next;
        sa_reg   <= sa_next;
        sb_reg   <= sb_next;
        ea_reg   <= ea_next;
        eb_reg   <= eb_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        sgn_reg  <= sgn_next;
        ex_reg   <= ex_next;
        r_reg    <= r_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        cnt_reg  <= cnt_next;
        dist_reg <= dist_next;
        sub_reg  <= sub_next;
        res_reg  <= res_next;
    end

    assign done   = (state_reg == F_DONE);
    assign result = res_reg;

`ifndef SYNTHESIS
    // Normalization only ever runs on a nonzero significand.
    a_norm_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == F_NORM) |-> (r_reg != 50'd0))
        else $error("normalizer entered with a zero significand");
`endif

endmodule

// ----- rtl/nsf_dp.sv -----
module nsf_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  nsf_pkg::nsf_cmd_t              cmd,
    output nsf_pkg::nsf_status_t           status,
    input  logic [31:0]                    s_value_bits,
    input  logic                           cfg_valid,
    input  logic [nsf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                    cfg_data,
    output logic [31:0]                    m_root_bits,
    output logic                           m_converged
);
    import nsf_pkg::*;

    logic [31:0] a_reg, x0_reg, x1_reg, t_reg;
    logic [31:0] tol_reg;
    logic [6:0]  maxit_reg, lim_reg, iter_reg;
    logic        odd_reg, flag_reg;
    logic [31:0] root_reg;
    logic        conv_reg;

    logic [7:0]  field;
    logic [7:0]  new_exp;
    logic [31:0] guess;
    logic [6:0]  lim_new;
    fop_t        fpu_op;
    logic [31:0] opa, opb;
    logic        fpu_done;
    logic [31:0] fpu_res;
    logic [31:0] abs_d;
    logic        conv_hit;
    logic        last_iter;

    // First guess: halve a positive unbiased exponent, shift the mantissa field.
    assign field   = s_value_bits[30:23];
    assign new_exp = (field > EXP_BIAS) ? (((field - EXP_BIAS) >> 1) + EXP_BIAS) : EXP_BIAS;
    assign guess   = {s_value_bits[31], new_exp, 1'b0, s_value_bits[22:1]};
    assign lim_new = (maxit_reg == 7'd0) ? 7'd1
                   : ((maxit_reg > ITER_CAP) ? ITER_CAP : maxit_reg);

    // Operand selection for each step.
    always_comb begin
        case (cmd.step)
            STEP_GUESS: begin
                fpu_op = FOP_MUL;
                opa    = x0_reg;
                opb    = SQRT2_BITS;
            end
            STEP_DIV: begin
                fpu_op = FOP_DIV;
                opa    = a_reg;
                opb    = x0_reg;
            end
            STEP_ADD: begin
                fpu_op = FOP_ADD;
                opa    = x0_reg;
                opb    = t_reg;
            end
            STEP_HALF: begin
                fpu_op = FOP_MUL;
                opa    = t_reg;
                opb    = HALF_BITS;
            end
            default: begin
                fpu_op = FOP_SUB;
                opa    = x1_reg;
                opb    = x0_reg;
            end
        endcase
    end

    nsf_fpu u_fpu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.start),
        .op      (fpu_op),
        .a       (opa),
        .b       (opb),
        .done    (fpu_done),
        .result  (fpu_res)
    );

    // Stop test on the difference held in the scratch register.
    assign abs_d     = fp_lt(t_reg, 32'd0) ? {~t_reg[31], t_reg[30:0]} : t_reg;
    assign conv_hit  = fp_eq(x0_reg, x1_reg) || fp_lt(abs_d, tol_reg);
    assign last_iter = (iter_reg + 7'd1) == lim_reg;

    always_comb begin
        status.guess_odd = odd_reg;
        status.conv_hit  = conv_hit;
        status.last_iter = last_iter;
        status.fpu_done  = fpu_done;
    end

    // Configuration registers and loop counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg   <= TOL_RESET;
            maxit_reg <= MAXIT_RESET;
            iter_reg  <= 7'd0;
            lim_reg   <= 7'd1;
        end else begin
            if (cfg_valid && (cfg_index == CFG_TOLERANCE)) begin
                tol_reg <= cfg_data;
            end
            if (cfg_valid && (cfg_index == CFG_MAX_ITER)) begin
                maxit_reg <= cfg_data[6:0];
            end
            if (cmd.load) begin
                iter_reg <= 7'd0;
                lim_reg  <= lim_new;
            end else if (cmd.check) begin
                iter_reg <= iter_reg + 7'd1;
            end
        end
    end

    // Working values of the current word.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            a_reg   <= s_value_bits;
            x0_reg  <= guess;
            odd_reg <= ~field[0];
        end
        if (cmd.capture) begin
            case (cmd.step)
                STEP_GUESS: x0_reg <= fpu_res;
                STEP_HALF:  x1_reg <= fpu_res;
                default:    t_reg  <= fpu_res;
            endcase
        end
        if (cmd.check) begin
            flag_reg <= conv_hit;
            if (!conv_hit && !last_iter) begin
                x0_reg <= x1_reg;
            end
        end
        if (cmd.out_load) begin
            root_reg <= x1_reg;
            conv_reg <= flag_reg;
        end
    end

    assign m_root_bits = root_reg;
    assign m_converged = conv_reg;

`ifndef SYNTHESIS
    // The step counter never runs past the latched limit.
    a_iter_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        iter_reg <= lim_reg)
        else $error("iteration counter passed its limit");
`endif

endmodule

// ----- rtl/nsf_ctrl.sv -----
module nsf_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  nsf_pkg::nsf_status_t  status,
    output nsf_pkg::nsf_cmd_t     cmd
);
    import nsf_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PREP   = 3'd1;
    localparam logic [2:0] S_ISSUE  = 3'd2;
    localparam logic [2:0] S_WAIT   = 3'd3;
    localparam logic [2:0] S_CHECK  = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0] state_reg, state_next;
    step_t      step_reg, step_next;
    logic       m_valid_reg, m_valid_next;

    // Step sequencing: guess scaling, then divide, add, halve, difference, test.
    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        cmd          = '0;
        cmd.step     = step_reg;
        s_ready      = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                step_next  = status.guess_odd ? STEP_GUESS : STEP_DIV;
                state_next = S_ISSUE;
            end
            S_ISSUE: begin
                cmd.start  = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT: begin
                if (status.fpu_done) begin
                    cmd.capture = 1'b1;
                    state_next  = S_ISSUE;
                    case (step_reg)
                        STEP_GUESS: step_next = STEP_DIV;
                        STEP_DIV:   step_next = STEP_ADD;
                        STEP_ADD:   step_next = STEP_HALF;
                        STEP_HALF:  step_next = STEP_DIFF;
                        default:    state_next = S_CHECK;
                    endcase
                end
            end
            S_CHECK: begin
                cmd.check = 1'b1;
                if (status.conv_hit || status.last_iter) begin
                    state_next = S_FINISH;
                end else begin
                    step_next  = STEP_DIV;
                    state_next = S_ISSUE;
                end
            end
            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result word holding register.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            step_reg    <= STEP_DIV;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

`ifndef SYNTHESIS
    // The float unit only finishes while the controller waits for it.
    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        status.fpu_done |-> (state_reg == S_WAIT))
        else $error("float unit finished outside the wait state");

    // A new result word never overwrites one still waiting.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result word overwritten before it was taken");

    // Reset leaves the controller ready for a word.
    a_idle_after_reset: assert property (@(posedge aclk)
        $rose(aresetn) |-> (state_reg == S_IDLE) && !m_valid_reg)
        else $error("controller not idle after reset");
`endif

endmodule

// ----- rtl/newton_sqrt_float32_unit.sv -----
// Newton-Raphson square root of one binary32 word. A first guess is built from the
// operand's exponent and mantissa fields, then x = (x + A/x) * 0.5 is repeated in
// binary32 arithmetic with round-to-nearest-even until two estimates are equal, their
// distance is below the tolerance register, or the iteration limit is hit; the result
// carries the last estimate and a converged flag. One word is processed at a time and
// the next is accepted while a finished result still waits on the output. All
// arithmetic goes through a single multi-cycle float unit, so latency is set by it.
// Apart from the operations, an item passes through accept, guess setup and result
// hand-off. Each float operation is an issue step plus the unit's sequence; a divide
// runs in a radix-2 divider. The guess scaling is added when the exponent is odd.
// A Newton step is four operations and one test. Subnormal operands add steps of
// pre-normalization and cancellation in the subtraction adds steps of normalization.
// NaN, infinite and zero operands skip the arithmetic. Configuration writes are
// taken at any time and should be done while the block is idle.
module newton_sqrt_float32_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [31:0]                    s_value_bits,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [31:0]                    m_root_bits,
    output logic                           m_converged,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [nsf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                    cfg_data
);
    import nsf_pkg::*;

    nsf_cmd_t    cmd;
    nsf_status_t status;

    // Register writes are always taken.
    assign cfg_ready = 1'b1;

    nsf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    nsf_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .s_value_bits (s_value_bits),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .m_root_bits  (m_root_bits),
        .m_converged  (m_converged)
    );

endmodule
